// ===== rtl/core/pulse_edge_timing_capture_macros.svh =====
// Assertion macros shared by the checker files of the capture block.
// Depends on nothing; take it in with a bare-name include.
`ifndef PULSE_EDGE_TIMING_CAPTURE_MACROS_SVH
`define PULSE_EDGE_TIMING_CAPTURE_MACROS_SVH

// Check a property on every clock edge while reset is released.
`define PETC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PETC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/petc_pkg.sv =====
// Shared constants for the pulse edge timing capture block.
// No dependencies; used by the channel interfaces, the top level and its checker.
package petc_pkg;

	localparam int unsigned ACTION_W  = 2;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned LIMIT_W   = 16;
	localparam int unsigned APB_DW    = 32;
	localparam int unsigned PADDR_W   = 5;
	localparam int unsigned REG_IDX_W = 3;

	typedef logic [ACTION_W-1:0]  action_t;
	typedef logic [TIME_W-1:0]    time_t;
	typedef logic [LIMIT_W-1:0]   limit_t;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	// request actions
	localparam action_t ACT_RISE  = 2'd0;
	localparam action_t ACT_FALL  = 2'd1;
	localparam action_t ACT_CLEAR = 2'd2;

	// register indexes, byte address is four times the index
	localparam reg_idx_t REG_COUNT_ENABLE   = 3'd0;
	localparam reg_idx_t REG_RANGE_ENABLES  = 3'd1;
	localparam reg_idx_t REG_PERIOD_MIN     = 3'd2;
	localparam reg_idx_t REG_PERIOD_MAX     = 3'd3;
	localparam reg_idx_t REG_LOW_WIDTH_MIN  = 3'd4;
	localparam reg_idx_t REG_LOW_WIDTH_MAX  = 3'd5;
	localparam reg_idx_t REG_HIGH_WIDTH_MIN = 3'd6;
	localparam reg_idx_t REG_HIGH_WIDTH_MAX = 3'd7;

	// bit positions in the range check enable register
	localparam int unsigned RC_PERIOD     = 0;
	localparam int unsigned RC_LOW_WIDTH  = 1;
	localparam int unsigned RC_HIGH_WIDTH = 2;

endpackage

// ===== rtl/core/petc_if.sv =====
// Valid/ready channel interfaces for the capture block: edge requests in, reports out.
// Depends on petc_pkg.
interface petc_capture_if;
	logic              valid;
	logic              ready;
	petc_pkg::action_t action;
	petc_pkg::time_t   timestamp;

	modport source (output valid, action, timestamp, input ready);
	modport sink (input valid, action, timestamp, output ready);
endinterface

interface petc_report_if;
	logic            valid;
	logic            ready;
	petc_pkg::time_t period;
	petc_pkg::time_t low_width;
	petc_pkg::time_t high_width;
	petc_pkg::time_t edge_total;
	logic            falling_event;

	modport source (output valid, period, low_width, high_width, edge_total, falling_event,
		input ready);
	modport sink (input valid, period, low_width, high_width, edge_total, falling_event,
		output ready);
endinterface

// ===== rtl/core/pulse_edge_timing_capture.sv =====
// Pulse edge timing capture: edge ring, falling counter, width/period report.
// Depends on petc_pkg and the channel interfaces in petc_if.sv.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------------------------
//  capture  | in  | valid/ready        | action, timestamp
//  report   | out | valid/ready        | period, low_width, high_width, edge_total,
//           |     |                    | falling_event
//  apb      | in  | psel/penable/pready| paddr, pwdata, pwrite, prdata
//
// One request enters per cycle unless the report stalls; its report passes through the
// input register, the ring read register, then the report register.
// The ring update for one request completes in the cycle it leaves the input register,
// so requests follow each other without bubbles.
// Reset clears the valid bits of both rings at once; no clearing pass is run.
// A stalled report holds the report register, then the ring read register, then
// the input register, and only then drops capture.ready.
module pulse_edge_timing_capture #(
	parameter int unsigned RING_DEPTH = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [petc_pkg::PADDR_W-1:0] paddr,
	input  logic [petc_pkg::APB_DW-1:0]  pwdata,
	output logic [petc_pkg::APB_DW-1:0]  prdata,
	output logic                      pready,
	petc_capture_if.sink              capture,
	petc_report_if.source             report
);

	localparam int unsigned PTR_W  = $clog2(RING_DEPTH);
	localparam int unsigned FILL_W = $clog2(RING_DEPTH + 1);

	typedef logic [PTR_W-1:0] ptr_t;

	// configuration registers
	logic                      count_enable_q;
	logic [2:0]                range_en_q;
	petc_pkg::limit_t          period_min_q;
	petc_pkg::limit_t          period_max_q;
	petc_pkg::limit_t          low_min_q;
	petc_pkg::limit_t          low_max_q;
	petc_pkg::limit_t          high_min_q;
	petc_pkg::limit_t          high_max_q;

	// ring state
	petc_pkg::time_t           rise_mem [RING_DEPTH];
	petc_pkg::time_t           fall_mem [RING_DEPTH];
	logic [RING_DEPTH-1:0]     rise_vld_q;
	logic [RING_DEPTH-1:0]     fall_vld_q;
	ptr_t                      wr_slot_q;
	ptr_t                      last_slot_q;
	logic [FILL_W-1:0]         fill_q;
	petc_pkg::time_t           fall_cnt_q;

	// input register
	logic                      valid_s1;
	petc_pkg::action_t         act_s1;
	petc_pkg::time_t           ts_s1;

	// ring read register
	logic                      valid_s2;
	logic                      full_s2;
	logic                      fell_s2;
	petc_pkg::time_t           total_s2;
	petc_pkg::time_t           ts_s2;
	petc_pkg::time_t           fl_rd_s2;
	petc_pkg::time_t           fp_rd_s2;
	petc_pkg::time_t           rl_rd_s2;
	logic                      fl_byp_s2;
	logic                      fl_vld_s2;
	logic                      fp_vld_s2;
	logic                      rl_byp_s2;
	logic                      rl_vld_s2;

	// report register
	logic                      res_valid_q;
	petc_pkg::time_t           period_q;
	petc_pkg::time_t           low_width_q;
	petc_pkg::time_t           high_width_q;
	petc_pkg::time_t           edge_total_q;
	logic                      falling_event_q;

	// handshake and stage control
	logic                      cfg_wr;
	petc_pkg::reg_idx_t        cfg_idx;
	logic                      res_go;
	logic                      s2_free;
	logic                      s1_free;
	logic                      s1_go;
	logic                      cap_acc;

	// ring update of the request in the input register
	logic                      is_rise;
	logic                      is_fall;
	logic                      is_clr;
	ptr_t                      wr_nx;
	ptr_t                      last_nx;
	ptr_t                      prev_nx;
	logic [FILL_W-1:0]         fill_nx;
	petc_pkg::time_t           cnt_nx;

	// report arithmetic
	petc_pkg::time_t           fall_last;
	petc_pkg::time_t           fall_prev;
	petc_pkg::time_t           rise_last;
	petc_pkg::time_t           per_raw;
	petc_pkg::time_t           low_raw;
	petc_pkg::time_t           high_raw;
	petc_pkg::time_t           per_val;
	petc_pkg::time_t           low_val;
	petc_pkg::time_t           high_val;

	// Drop a value that sits outside its enabled window.
	function automatic petc_pkg::time_t range_gate(
		input petc_pkg::time_t  v,
		input logic             en,
		input petc_pkg::limit_t lo,
		input petc_pkg::limit_t hi
	);
		petc_pkg::time_t lo_w;
		petc_pkg::time_t hi_w;
		lo_w = petc_pkg::TIME_W'(lo);
		hi_w = petc_pkg::TIME_W'(hi);
		if (en && ((v < lo_w) || (v > hi_w))) begin
			return '0;
		end
		return v;
	endfunction

	//--------------------------------------------------------------------------
	// Configuration port: writes land on the access phase, reads are combinational.
	//--------------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[petc_pkg::PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_enable_q <= 1'b0;
			range_en_q     <= '0;
			period_min_q   <= '0;
			period_max_q   <= '0;
			low_min_q      <= '0;
			low_max_q      <= '0;
			high_min_q     <= '0;
			high_max_q     <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				petc_pkg::REG_COUNT_ENABLE:   count_enable_q <= pwdata[0];
				petc_pkg::REG_RANGE_ENABLES:  range_en_q     <= pwdata[2:0];
				petc_pkg::REG_PERIOD_MIN:     period_min_q   <= pwdata[15:0];
				petc_pkg::REG_PERIOD_MAX:     period_max_q   <= pwdata[15:0];
				petc_pkg::REG_LOW_WIDTH_MIN:  low_min_q      <= pwdata[15:0];
				petc_pkg::REG_LOW_WIDTH_MAX:  low_max_q      <= pwdata[15:0];
				petc_pkg::REG_HIGH_WIDTH_MIN: high_min_q     <= pwdata[15:0];
				petc_pkg::REG_HIGH_WIDTH_MAX: high_max_q     <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			petc_pkg::REG_COUNT_ENABLE:   prdata = petc_pkg::APB_DW'(count_enable_q);
			petc_pkg::REG_RANGE_ENABLES:  prdata = petc_pkg::APB_DW'(range_en_q);
			petc_pkg::REG_PERIOD_MIN:     prdata = petc_pkg::APB_DW'(period_min_q);
			petc_pkg::REG_PERIOD_MAX:     prdata = petc_pkg::APB_DW'(period_max_q);
			petc_pkg::REG_LOW_WIDTH_MIN:  prdata = petc_pkg::APB_DW'(low_min_q);
			petc_pkg::REG_LOW_WIDTH_MAX:  prdata = petc_pkg::APB_DW'(low_max_q);
			petc_pkg::REG_HIGH_WIDTH_MIN: prdata = petc_pkg::APB_DW'(high_min_q);
			petc_pkg::REG_HIGH_WIDTH_MAX: prdata = petc_pkg::APB_DW'(high_max_q);
			default:                      prdata = '0;
		endcase
	end

	//--------------------------------------------------------------------------
	// Stage control. Each stage advances when the one after it is empty or
	// empties in the same cycle, so a full pipe moves every cycle the report is taken.
	//--------------------------------------------------------------------------
	assign res_go        = !res_valid_q || report.ready;
	assign s2_free       = !valid_s2 || res_go;
	assign s1_free       = !valid_s1 || s2_free;
	assign s1_go         = valid_s1 && s2_free;
	assign capture.ready = s1_free;
	assign cap_acc       = capture.valid && s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			valid_s1    <= cap_acc || (valid_s1 && !s2_free);
			valid_s2    <= s1_go || (valid_s2 && !res_go);
			res_valid_q <= (valid_s2 && res_go) || (res_valid_q && !report.ready);
		end
	end

	// Hold the accepted request until it can move on.
	always_ff @(posedge clk) begin
		if (cap_acc) begin
			act_s1 <= capture.action;
			ts_s1  <= capture.timestamp;
		end
	end

	//--------------------------------------------------------------------------
	// Ring update. A rise writes the current slot; a fall writes it too, makes
	// it the last completed slot and advances. Any edge raises the fill count
	// up to the ring depth. Clear wipes pointers, counts and valid bits.
	//--------------------------------------------------------------------------
	assign is_rise = (act_s1 == petc_pkg::ACT_RISE);
	assign is_fall = (act_s1 == petc_pkg::ACT_FALL);
	assign is_clr  = (act_s1 == petc_pkg::ACT_CLEAR);

	always_comb begin
		wr_nx   = wr_slot_q;
		last_nx = last_slot_q;
		fill_nx = fill_q;
		cnt_nx  = fall_cnt_q;
		if (is_fall) begin
			last_nx = wr_slot_q;
			wr_nx   = (wr_slot_q == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_slot_q + PTR_W'(1);
			if (count_enable_q) begin
				cnt_nx = fall_cnt_q + petc_pkg::TIME_W'(1);
			end
		end
		if ((is_rise || is_fall) && (fill_q < FILL_W'(RING_DEPTH))) begin
			fill_nx = fill_q + FILL_W'(1);
		end
		if (is_clr) begin
			wr_nx   = '0;
			last_nx = '0;
			fill_nx = '0;
			cnt_nx  = '0;
		end
		prev_nx = (last_nx == '0) ? PTR_W'(RING_DEPTH - 1) : last_nx - PTR_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_slot_q   <= '0;
			last_slot_q <= '0;
			fill_q      <= '0;
			fall_cnt_q  <= '0;
			rise_vld_q  <= '0;
			fall_vld_q  <= '0;
		end else if (s1_go) begin
			wr_slot_q   <= wr_nx;
			last_slot_q <= last_nx;
			fill_q      <= fill_nx;
			fall_cnt_q  <= cnt_nx;
			if (is_clr) begin
				rise_vld_q <= '0;
				fall_vld_q <= '0;
			end else if (is_rise) begin
				rise_vld_q[wr_slot_q] <= 1'b1;
			end else if (is_fall) begin
				fall_vld_q[wr_slot_q] <= 1'b1;
			end
		end
	end

	// Ring memories: one write and registered reads of the slots the report needs.
	always_ff @(posedge clk) begin
		if (s1_go) begin
			if (is_rise) begin
				rise_mem[wr_slot_q] <= ts_s1;
			end
			if (is_fall) begin
				fall_mem[wr_slot_q] <= ts_s1;
			end
			fl_rd_s2 <= fall_mem[last_nx];
			fp_rd_s2 <= fall_mem[prev_nx];
			rl_rd_s2 <= rise_mem[last_nx];
		end
	end

	// Capture what the report needs; a write to a slot being read bypasses the memory.
	always_ff @(posedge clk) begin
		if (s1_go) begin
			full_s2   <= (fill_nx == FILL_W'(RING_DEPTH));
			fell_s2   <= is_fall;
			total_s2  <= cnt_nx;
			ts_s2     <= ts_s1;
			fl_byp_s2 <= is_fall;
			fl_vld_s2 <= fall_vld_q[last_nx];
			fp_vld_s2 <= fall_vld_q[prev_nx];
			rl_byp_s2 <= is_rise && (wr_slot_q == last_nx);
			rl_vld_s2 <= rise_vld_q[last_nx];
		end
	end

	//--------------------------------------------------------------------------
	// Report: wrapping differences, window check, zero until the ring is full.
	//--------------------------------------------------------------------------
	always_comb begin
		fall_last = fl_byp_s2 ? ts_s2 : (fl_vld_s2 ? fl_rd_s2 : '0);
		fall_prev = fp_vld_s2 ? fp_rd_s2 : '0;
		rise_last = rl_byp_s2 ? ts_s2 : (rl_vld_s2 ? rl_rd_s2 : '0);
		per_raw   = fall_last - fall_prev;
		low_raw   = rise_last - fall_prev;
		high_raw  = fall_last - rise_last;
		per_val   = range_gate(per_raw, range_en_q[petc_pkg::RC_PERIOD],
			period_min_q, period_max_q);
		low_val   = range_gate(low_raw, range_en_q[petc_pkg::RC_LOW_WIDTH],
			low_min_q, low_max_q);
		high_val  = range_gate(high_raw, range_en_q[petc_pkg::RC_HIGH_WIDTH],
			high_min_q, high_max_q);
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && res_go) begin
			period_q        <= full_s2 ? per_val : '0;
			low_width_q     <= full_s2 ? low_val : '0;
			high_width_q    <= full_s2 ? high_val : '0;
			edge_total_q    <= total_s2;
			falling_event_q <= fell_s2;
		end
	end

	assign report.valid         = res_valid_q;
	assign report.period        = period_q;
	assign report.low_width     = low_width_q;
	assign report.high_width    = high_width_q;
	assign report.edge_total    = edge_total_q;
	assign report.falling_event = falling_event_q;

endmodule

// ===== rtl/core/petc_checker.sv =====
// Port-level checker for the capture block and its bind to the top level.
// Depends on petc_pkg and pulse_edge_timing_capture_macros.svh.
`include "pulse_edge_timing_capture_macros.svh"

module petc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [petc_pkg::PADDR_W-1:0] paddr,
	input logic [petc_pkg::APB_DW-1:0]  pwdata,
	input logic [petc_pkg::APB_DW-1:0]  prdata,
	input logic                         cap_ready,
	input logic                         rep_valid,
	input logic                         rep_ready,
	input petc_pkg::time_t              rep_period,
	input petc_pkg::time_t              rep_low_width,
	input petc_pkg::time_t              rep_high_width,
	input petc_pkg::time_t              rep_edge_total,
	input logic                         rep_falling_event
);

	logic               wr_taken;
	petc_pkg::reg_idx_t rd_idx;

	assign wr_taken = psel && penable && pwrite;
	assign rd_idx   = paddr[petc_pkg::PADDR_W-1:2];

	// A waiting report holds still.
	`PETC_ASSERT(a_report_hold, clk, arst_n, rep_valid && !rep_ready |=> rep_valid && $stable(rep_period) && $stable(rep_low_width) && $stable(rep_high_width) && $stable(rep_edge_total) && $stable(rep_falling_event), "report changed while stalled")

	// An empty report register never blocks new requests.
	`PETC_ASSERT(a_ready_when_drained, clk, arst_n, !rep_valid |-> cap_ready, "capture stalled with no report pending")

	// Reset empties the report register.
	`PETC_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !rep_valid, "report valid during reset")

	// A limit register reads back the low half of what was written.
	`PETC_ASSERT(a_limit_readback, clk, arst_n, $past(arst_n) && $past(wr_taken) && psel && !pwrite && paddr == $past(paddr) && rd_idx >= petc_pkg::REG_PERIOD_MIN |-> prdata[31:16] == 16'h0 && prdata[15:0] == $past(pwdata[15:0]), "limit readback mismatch")

	// Narrow control registers read back with their unused bits clear.
	`PETC_ASSERT(a_ctrl_unused_zero, clk, arst_n, psel && (rd_idx == petc_pkg::REG_COUNT_ENABLE || rd_idx == petc_pkg::REG_RANGE_ENABLES) |-> prdata[31:3] == 29'h0, "control register unused bits set")

endmodule

bind pulse_edge_timing_capture petc_checker u_petc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.psel              (psel),
	.penable           (penable),
	.pwrite            (pwrite),
	.paddr             (paddr),
	.pwdata            (pwdata),
	.prdata            (prdata),
	.cap_ready         (capture.ready),
	.rep_valid         (report.valid),
	.rep_ready         (report.ready),
	.rep_period        (report.period),
	.rep_low_width     (report.low_width),
	.rep_high_width    (report.high_width),
	.rep_edge_total    (report.edge_total),
	.rep_falling_event (report.falling_event)
);
